>>> design/dttf_pkg.sv
// Package for the date-time text parser.
// Holds the parse state and result types, character codes and register codes.
// Used by dttf_char_step and datetime_text_to_fields.
package dttf_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned PAIR_W = 7;
  localparam int unsigned POS_W  = 5;

  typedef enum logic [0:0] {
    CFG_DELIMITED  = 1'b0,
    CFG_DATE_ORDER = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ORDER_YMD = 2'd0,
    ORDER_YDM = 2'd1,
    ORDER_MDY = 2'd2,
    ORDER_DMY = 2'd3
  } date_order_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [YEAR_W-1:0] year;
    logic [PAIR_W-1:0] pair1;
    logic [PAIR_W-1:0] pair2;
    logic [PAIR_W-1:0] hour;
    logic [PAIR_W-1:0] minute;
    logic [PAIR_W-1:0] second;
    logic              date_blank;
    logic              time_blank;
    logic              err;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    pos: '0, year: '0, pair1: '0, pair2: '0, hour: '0, minute: '0, second: '0,
    date_blank: 1'b1, time_blank: 1'b1, err: 1'b0
  };

  typedef struct packed {
    logic              bad_format;
    logic [PAIR_W-1:0] second;
    logic [PAIR_W-1:0] minute;
    logic [PAIR_W-1:0] hour;
    logic [PAIR_W-1:0] day;
    logic [PAIR_W-1:0] month;
    logic [YEAR_W-1:0] year;
  } result_t;

endpackage

>>> design/datetime_text_to_fields.sv
// Top level of the fixed-layout date-time text parser.
// Holds the parse state, configuration registers and a two-entry result buffer.
// Depends on dttf_pkg and dttf_char_step.
//
//  channel  direction  payload
//  s_*      in         tdata[7:0] char_code, tlast end_of_record
//  m_*      out        tdata year..second, tuser bad_format
//  cfg_*    in         cfg_index register, cfg_data value
//
// One character per cycle while s_tready is high; the per-character accumulator update sets the path.
// A record's last character registers its result in the output slot, or in the skid slot if that is held.
// Reset clears the record, sets delimited to 1 and date order to year-month-day.
// Characters keep flowing while a result waits; s_tready drops only when both
// result slots hold requests.
module datetime_text_to_fields import dttf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [13:0] year, [20:14] month, [27:21] day,
                                 // [34:28] hour, [41:35] minute, [48:42] second
  output logic [0:0]  m_tuser,   // [0] bad_format
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic         delimited;
  date_order_t  date_order;
  parse_state_t state;
  parse_state_t state_next;
  logic         bad_format;
  result_t      res_next;
  result_t      out_res;
  result_t      skid_res;
  logic         out_valid;
  logic         skid_valid;
  logic         accept;
  logic         push;
  logic         pop;
  logic         month_first;

  dttf_char_step u_step (
    .cur        (state),
    .char_code  (s_tdata),
    .delimited  (delimited),
    .date_order (date_order),
    .upd        (state_next),
    .bad_format (bad_format)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign push      = accept && s_tlast;
  assign pop       = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimited  <= 1'b1;
      date_order <= ORDER_YMD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DELIMITED:  delimited  <= cfg_data[0];
        CFG_DATE_ORDER: date_order <= date_order_t'(cfg_data);
        default:        delimited  <= delimited;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (accept) begin
      state <= s_tlast ? STATE_CLEAR : state_next;
    end
  end

  always_comb begin
    month_first         = (date_order == ORDER_YMD) || (date_order == ORDER_MDY);
    res_next.year       = state_next.year;
    res_next.month      = month_first ? state_next.pair1 : state_next.pair2;
    res_next.day        = month_first ? state_next.pair2 : state_next.pair1;
    res_next.hour       = state_next.hour;
    res_next.minute     = state_next.minute;
    res_next.second     = state_next.second;
    res_next.bad_format = bad_format;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_res <= res_next;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_res   <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.second, out_res.minute, out_res.hour,
                     out_res.day, out_res.month, out_res.year};
  assign m_tuser  = out_res.bad_format;

endmodule

>>> design/dttf_char_step.sv
// Per-character update of the date-time parse state.
// Decodes the character position and folds one digit into its accumulator.
// Depends on dttf_pkg.
module dttf_char_step import dttf_pkg::*; (
  input  parse_state_t cur,
  input  logic [7:0]   char_code,
  input  logic         delimited,
  input  date_order_t  date_order,
  output parse_state_t upd,
  output logic         bad_format
);

  function automatic logic [YEAR_W-1:0] mac_year(input logic [YEAR_W-1:0] acc,
                                                 input logic [3:0] d);
    mac_year = (acc << 3) + (acc << 1) + YEAR_W'(d);
  endfunction

  function automatic logic [PAIR_W-1:0] mac_pair(input logic [PAIR_W-1:0] acc,
                                                 input logic [3:0] d);
    mac_pair = (acc << 3) + (acc << 1) + PAIR_W'(d);
  endfunction

  logic             is_digit;
  logic             is_space;
  logic [3:0]       digit;
  logic [POS_W-1:0] date_len;
  logic [POS_W-1:0] time_start;
  logic [POS_W-1:0] rec_len;
  logic             year_first;
  logic [POS_W-1:0] delim_a;
  logic [POS_W-1:0] delim_b;
  logic [POS_W-1:0] k_full;
  logic [2:0]       k;
  logic [POS_W-1:0] t_full;
  logic [2:0]       t;
  logic [1:0]       group;
  logic             in_date;
  logic             in_time;
  logic             date_digit;
  logic             time_digit;
  logic             err;

  always_comb begin
    upd        = cur;
    err        = 1'b0;
    is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    is_space   = (char_code == CHAR_SPACE);
    digit      = is_digit ? char_code[3:0] : 4'd0;
    date_len   = delimited ? POS_W'(10) : POS_W'(8);
    time_start = date_len + POS_W'(1);
    rec_len    = time_start + (delimited ? POS_W'(8) : POS_W'(6));
    year_first = (date_order == ORDER_YMD) || (date_order == ORDER_YDM);
    delim_a    = year_first ? POS_W'(4) : POS_W'(2);
    delim_b    = delim_a + POS_W'(3);
    k_full     = cur.pos - POS_W'(delimited && (cur.pos > delim_a))
                 - POS_W'(delimited && (cur.pos > delim_b));
    k          = k_full[2:0];
    t_full     = cur.pos - time_start;
    t          = t_full[2:0];
    in_date    = cur.pos < date_len;
    in_time    = (cur.pos >= time_start) && (cur.pos < rec_len);
    date_digit = !(delimited && ((cur.pos == delim_a) || (cur.pos == delim_b)));
    time_digit = !(delimited && ((t == 3'd2) || (t == 3'd5)));
    if (delimited) begin
      group = (t < 3'd3) ? 2'd0 : ((t < 3'd6) ? 2'd1 : 2'd2);
    end else begin
      group = t[2:1];
    end

    if (in_date) begin
      if (is_space) begin
        err = date_digit && !cur.date_blank;
      end else begin
        err = (cur.date_blank && (cur.pos != '0)) || (date_digit && !is_digit);
        upd.date_blank = 1'b0;
      end
      if (date_digit) begin
        if (k[2] != year_first) begin
          upd.year = mac_year(cur.year, digit);
        end else if (!k[1]) begin
          upd.pair1 = mac_pair(cur.pair1, digit);
        end else begin
          upd.pair2 = mac_pair(cur.pair2, digit);
        end
      end
    end else if (in_time) begin
      if (is_space) begin
        err = time_digit && !cur.time_blank;
      end else begin
        err = (cur.time_blank && (t != 3'd0)) || (time_digit && !is_digit);
        upd.time_blank = 1'b0;
      end
      if (time_digit) begin
        if (group == 2'd0) begin
          upd.hour = mac_pair(cur.hour, digit);
        end else if (group == 2'd1) begin
          upd.minute = mac_pair(cur.minute, digit);
        end else begin
          upd.second = mac_pair(cur.second, digit);
        end
      end
    end

    if (cur.pos != '1) begin
      upd.pos = cur.pos + POS_W'(1);
    end
    upd.err    = cur.err || err;
    bad_format = upd.err || (cur.pos != rec_len - POS_W'(1));
  end

endmodule

>>> design/dttf_checker.sv
// Port-level checks for the date-time text parser.
// Bound to datetime_text_to_fields; depends on its ports only.
module dttf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result payload changed while stalled");

  a_rise_from_eor: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result request without a record end");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
    else $error("result request from a mid-record character");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind datetime_text_to_fields dttf_checker u_dttf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> bench/tb_top.sv
// Self-checking bench for datetime_text_to_fields: streams date-time records
// under every date order and both layouts, predicts the fields, checks results.
// Depends on dttf_pkg and the design files under design/.
module tb_top;
  import dttf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_CHARS = 175;
  localparam int FIXED_PHASES = 8;
  localparam int PHASES = 10;

  localparam logic DELIM_PLAN [FIXED_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam date_order_t ORDER_PLAN [FIXED_PHASES] = '{ORDER_YMD, ORDER_DMY, ORDER_DMY,
      ORDER_YDM, ORDER_MDY, ORDER_MDY, ORDER_YDM, ORDER_YMD};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 1'b0;
  logic [1:0]  cfg_data = 2'd0;

  datetime_text_to_fields dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Parser shadow: layout registers and per-record accumulators.
  logic              cfg_delim = 1'b1;
  date_order_t       cfg_order = ORDER_YMD;
  logic [POS_W-1:0]  pos_q = '0;
  logic [YEAR_W-1:0] year_q = '0;
  logic [PAIR_W-1:0] pair1_q = '0, pair2_q = '0;
  logic [PAIR_W-1:0] hour_q = '0, minute_q = '0, second_q = '0;
  logic              date_blank_q = 1'b1, time_blank_q = 1'b1, err_q = 1'b0;

  text_char_t char_backlog [$];
  result_t    fields_due [$];
  int chars_queued = 0;
  int chars_taken = 0;
  int records_checked = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int send_gap = 0, send_calm = 0;
  int hold_left = 0, recv_calm = 0;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic logic part_err(input logic blank, input logic digit_pos, input logic first,
                                    input logic [7:0] c, output logic blank_next);
    blank_next = blank;
    if (c == CHAR_SPACE) return digit_pos && !blank;
    blank_next = 1'b0;
    return (blank && !first) || (digit_pos && !is_digit(c));
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic last);
    int unsigned p, date_len, time_start, rec_len, a, b, k, pk, t, g, dig;
    logic digit_pos, err, year_first, blank_n;
    result_t r;
    p = pos_q;
    date_len = cfg_delim ? 10 : 8;
    time_start = date_len + 1;
    rec_len = time_start + (cfg_delim ? 8 : 6);
    dig = is_digit(c) ? c - CHAR_ZERO : 0;
    year_first = (cfg_order == ORDER_YMD) || (cfg_order == ORDER_YDM);
    err = 1'b0;
    digit_pos = 1'b1;
    if (p < date_len) begin
      k = p;
      if (cfg_delim) begin
        a = year_first ? 4 : 2;
        b = a + 3;
        digit_pos = (p != a) && (p != b);
        k = p - (p > a ? 1 : 0) - (p > b ? 1 : 0);
      end
      err = part_err(date_blank_q, digit_pos, p == 0, c, blank_n);
      date_blank_q = blank_n;
      if (digit_pos) begin
        pk = year_first ? k - 4 : k;
        if (year_first ? (k < 4) : (k >= 4)) year_q = YEAR_W'(year_q * 10 + dig);
        else if (pk < 2) pair1_q = PAIR_W'(pair1_q * 10 + dig);
        else pair2_q = PAIR_W'(pair2_q * 10 + dig);
      end
    end else if (p >= time_start && p < rec_len) begin
      t = p - time_start;
      if (cfg_delim) begin
        digit_pos = (t != 2) && (t != 5);
        g = t / 3;
      end else begin
        g = t / 2;
      end
      err = part_err(time_blank_q, digit_pos, t == 0, c, blank_n);
      time_blank_q = blank_n;
      if (digit_pos) begin
        if (g == 0) hour_q = PAIR_W'(hour_q * 10 + dig);
        else if (g == 1) minute_q = PAIR_W'(minute_q * 10 + dig);
        else second_q = PAIR_W'(second_q * 10 + dig);
      end
    end
    err_q = err_q || err;
    if (pos_q < 31) pos_q = pos_q + 1'b1;
    if (!last) return;
    r.year = year_q;
    if (cfg_order == ORDER_YMD || cfg_order == ORDER_MDY) begin
      r.month = pair1_q;
      r.day = pair2_q;
    end else begin
      r.month = pair2_q;
      r.day = pair1_q;
    end
    r.hour = hour_q;
    r.minute = minute_q;
    r.second = second_q;
    r.bad_format = err_q || (p != rec_len - 1);
    fields_due.insert(fields_due.size(), r);
    pos_q = '0;
    year_q = '0;
    pair1_q = '0;
    pair2_q = '0;
    hour_q = '0;
    minute_q = '0;
    second_q = '0;
    date_blank_q = 1'b1;
    time_blank_q = 1'b1;
    err_q = 1'b0;
  endfunction

  // Mostly no gap, often a short one, rarely a long one; calm runs have none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  always @(posedge clk) begin : drive_chars
    text_char_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_char(s_tdata, s_tlast);
        chars_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (char_backlog.size() > 0) begin
          nxt = char_backlog.pop_front();
          s_tdata <= nxt.code;
          s_tlast <= nxt.last;
          s_tvalid <= 1'b1;
          send_gap = next_gap(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch_fields
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (fields_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = fields_due.pop_front();
          check_field("year", want.year, m_tdata[13:0]);
          check_field("month", want.month, m_tdata[20:14]);
          check_field("day", want.day, m_tdata[27:21]);
          check_field("hour", want.hour, m_tdata[34:28]);
          check_field("minute", want.minute, m_tdata[41:35]);
          check_field("second", want.second, m_tdata[48:42]);
          check_field("bad_format", want.bad_format, m_tuser[0]);
          records_checked++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_left = next_gap(recv_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_record(input logic [7:0] txt [$]);
    text_char_t item;
    foreach (txt[i]) begin
      item.code = txt[i];
      item.last = (i == txt.size() - 1);
      char_backlog.insert(char_backlog.size(), item);
      chars_queued++;
    end
  endtask

  task automatic wait_idle();
    while (chars_taken != chars_queued || fields_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input cfg_index_t idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DELIMITED) cfg_delim = val[0];
    else cfg_order = date_order_t'(val);
  endtask

  function automatic logic [7:0] pick_char(input logic [7:0] usual);
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : usual;
  endfunction

  function automatic logic [7:0] rand_digit();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // One record for the current layout: mostly well formed, the rest damaged.
  task automatic make_record();
    logic [7:0] txt [$];
    int date_len, time_len, rec_len, a, r, n, lo, hi;
    date_len = cfg_delim ? 10 : 8;
    time_len = cfg_delim ? 8 : 6;
    rec_len = date_len + 1 + time_len;
    a = (cfg_order == ORDER_YMD || cfg_order == ORDER_YDM) ? 4 : 2;
    for (int i = 0; i < date_len; i++)
      txt.insert(txt.size(),
                 (cfg_delim && (i == a || i == a + 3)) ? pick_char("-") : rand_digit());
    txt.insert(txt.size(), pick_char("T"));
    for (int t = 0; t < time_len; t++)
      txt.insert(txt.size(),
                 (cfg_delim && (t == 2 || t == 5)) ? pick_char(":") : rand_digit());
    r = $urandom_range(0, 99);
    if (r < 60) begin
    end else if (r < 76) begin
      lo = (r < 72) ? 0 : date_len + 1;
      hi = (r < 66 || r >= 72) ? date_len : rec_len;
      if (r >= 66 && r < 72) lo = date_len + 1;
      if (r >= 72) begin
        lo = 0;
        hi = rec_len;
      end
      for (int i = lo; i < hi; i++)
        if (i != date_len && ($urandom_range(0, 3) != 0 || txt[i] == rand_digit() || 1))
          txt[i] = ($urandom_range(0, 7) == 0) ? txt[i] : CHAR_SPACE;
    end else if (r < 82) begin
      txt[$urandom_range(0, rec_len - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 86) begin
      lo = $urandom_range(0, 1) ? 0 : date_len + 1;
      hi = (lo == 0) ? date_len : time_len;
      n = $urandom_range(1, hi - 1);
      for (int i = 0; i < n; i++) txt[lo + i] = CHAR_SPACE;
    end else if (r < 90) begin
      txt[$urandom_range(0, rec_len - 1)] = CHAR_SPACE;
    end else if (r < 96) begin
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, rec_len - 1);
        while (txt.size() > n) void'(txt.pop_back());
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) txt.insert(txt.size(), pick_char(rand_digit()));
      end
    end else begin
      txt.delete();
      n = $urandom_range(1, 40);
      repeat (n) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end
    push_record(txt);
  endtask

  initial begin : run_phases
    int start;
    logic delim;
    date_order_t order;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset layout: all nines, then one-character records at both code extremes.
    push_record('{"9", "9", "9", "9", "-", "9", "9", "-", "9", "9", "T",
                  "9", "9", ":", "9", "9", ":", "9", "9"});
    push_record('{8'hFF});
    push_record('{8'h00});

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph < FIXED_PHASES) begin
        delim = DELIM_PLAN[ph];
        order = ORDER_PLAN[ph];
      end else begin
        delim = 1'($urandom_range(0, 1));
        order = date_order_t'($urandom_range(0, 3));
      end
      write_reg(CFG_DELIMITED, {1'($urandom_range(0, 1)), delim});
      write_reg(CFG_DATE_ORDER, order);
      cfg_valid <= 1'b0;
      start = chars_queued;
      while (chars_queued - start < PHASE_CHARS) make_record();
    end

    wait_idle();
    $display("Checked %0d records from %0d characters across %0d register settings,",
             records_checked, chars_taken, PHASES + 1);
    $display("both layouts, all four date orders, blank parts, bad digits and bad lengths.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
